@@ sv/gat_pkg.sv @@
package gat_pkg;

  // Default sizes of the graph store.
  localparam int unsigned MaxNodesDef = 64;
  localparam int unsigned MaxEdgesDef = 1024;

  // Fixed widths of the channel fields.
  localparam int unsigned NodeW   = 6;
  localparam int unsigned CfgW    = 7;
  localparam int unsigned OpW     = 2;
  localparam int unsigned StatusW = 2;

  // A fetch returns at most this many neighbors.
  localparam int unsigned ResultCap  = 64;
  localparam int unsigned ResultCntW = $clog2(ResultCap + 1);

  // Node count after reset.
  localparam logic [CfgW-1:0] NodeCountRst = CfgW'(64);

  typedef enum logic [OpW-1:0] {
    OpLoad  = 2'd0,
    OpFetch = 2'd1,
    OpClear = 2'd2
  } opcode_e;

  typedef enum logic [StatusW-1:0] {
    StatusOk    = 2'd0,
    StatusRange = 2'd1,
    StatusFull  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StFlush
  } state_e;

  typedef struct packed {
    logic [OpW-1:0]   opcode;
    logic [NodeW-1:0] source_node;
    logic [NodeW-1:0] target_node;
    logic [NodeW-1:0] query_row;
  } in_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [NodeW-1:0]   neighbor;
    logic               has_neighbor;
    logic               last;
  } out_t;

  // One entry of the edge store.
  typedef struct packed {
    logic [NodeW-1:0] source;
    logic [NodeW-1:0] target;
  } edge_t;

endpackage

@@ sv/gat_edge_mem.sv @@
module gat_edge_mem
  import gat_pkg::*;
#(
  parameter int unsigned Depth = MaxEdgesDef,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  edge_t            wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output edge_t            rdata_o
);

  edge_t mem_q [Depth];
  edge_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // The read register holds its value while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/graph_adjacency_transpose.sv @@
// Transposed adjacency lists of a directed graph, one edge store scanned per fetch.
//
// Input items arrive on in_valid_i/in_ready_o with an in_t payload. A load
// stores one source/target pair, a clear empties the store, and a fetch
// returns the source of every stored edge whose target is the queried row,
// in load order. Results leave on out_valid_o/out_ready_i as out_t; the last
// result of every item has its last bit set, and an empty row gives a single
// result without a neighbor. The user must write the node count register through
// cfg_we_i/cfg_wdata_i only while the block is idle; the block does not enforce it.
//
// For load and clear items the result sits in the output register in the cycle
// after the transfer. A fetch walks the edge memory through its single read port,
// one edge per cycle unless a stall holds the scan. The input stays not ready
// until the fetch has sent its last result, and the scan stops early once 64
// neighbors have been found.
// If the receiver stalls, the scan pauses on the edge that needs to push a
// result and resumes when the output register frees up, so nothing is lost.
// Reset empties the store and sets the node count to 64; the memory contents
// are not cleared, since only entries below the edge count are ever read.
module graph_adjacency_transpose
  import gat_pkg::*;
#(
  parameter int unsigned MaxNodes = MaxNodesDef,
  parameter int unsigned MaxEdges = MaxEdgesDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  in_t             in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output out_t            out_data_o,
  input  logic            cfg_we_i,
  input  logic [CfgW-1:0] cfg_wdata_i
);

  localparam int unsigned AddrW   = $clog2(MaxEdges);
  localparam int unsigned TotW    = $clog2(MaxEdges + 1);
  localparam int unsigned MaxNW   = $clog2(MaxNodes + 1);
  localparam int unsigned LimW    = (MaxNW > CfgW) ? MaxNW : CfgW;
  localparam logic [LimW-1:0] MaxNodesL = LimW'(MaxNodes);
  localparam logic [TotW-1:0] MaxEdgesT = TotW'(MaxEdges);
  localparam logic [ResultCntW-1:0] CapC = ResultCntW'(ResultCap);

  state_e                state_q, state_d;
  logic [CfgW-1:0]       node_count_q;
  logic [TotW-1:0]       total_q, total_d;
  logic [TotW-1:0]       addr_q, addr_d;
  logic [ResultCntW-1:0] cnt_q, cnt_d;
  logic                  rd_valid_q, rd_valid_d;
  logic [NodeW-1:0]      row_q, row_d;
  logic [NodeW-1:0]      pend_q, pend_d;
  logic                  pend_valid_q, pend_valid_d;
  logic                  out_valid_q, out_valid_d;
  out_t                  out_q, out_d;

  logic [LimW-1:0] node_limit;
  logic            out_free;
  logic            in_fire;
  logic            mem_we;
  logic            mem_re;
  edge_t           mem_wdata;
  edge_t           mem_rdata;
  logic            hit;
  logic            stall;

  // Nodes are valid below min(node_count, MaxNodes).
  assign node_limit = (LimW'(node_count_q) > MaxNodesL) ? MaxNodesL : LimW'(node_count_q);

  // The output register can take a new result this cycle.
  assign out_free = !out_valid_q || out_ready_i;

  assign in_ready_o = (state_q == StIdle) && out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  // A stored edge that points at the fetched row, while the cap is not reached.
  assign hit   = rd_valid_q && (mem_rdata.target == row_q) && (cnt_q < CapC);
  // A second hit must push the held one out, which needs a free output register.
  assign stall = hit && pend_valid_q && !out_free;

  assign mem_we = in_fire && (opcode_e'(in_data_i.opcode) == OpLoad)
                  && (LimW'(in_data_i.source_node) < node_limit)
                  && (LimW'(in_data_i.target_node) < node_limit)
                  && (total_q < MaxEdgesT);

  assign mem_re = (state_q == StScan) && !stall && (addr_q < total_q) && (cnt_q < CapC);

  assign mem_wdata.source = in_data_i.source_node;
  assign mem_wdata.target = in_data_i.target_node;

  gat_edge_mem #(
    .Depth(MaxEdges),
    .AddrW(AddrW)
  ) u_edge_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(total_q[AddrW-1:0]),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(addr_q[AddrW-1:0]),
    .rdata_o(mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NodeCountRst;
    end else if (cfg_we_i) begin
      node_count_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      total_q      <= '0;
      addr_q       <= '0;
      cnt_q        <= '0;
      rd_valid_q   <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      total_q      <= total_d;
      addr_q       <= addr_d;
      cnt_q        <= cnt_d;
      rd_valid_q   <= rd_valid_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q  <= row_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  // Sequencer: accepts items in idle, walks the edge memory in scan, and
  // emits the final result of a fetch in flush.
  always_comb begin
    state_d      = state_q;
    total_d      = total_q;
    addr_d       = addr_q;
    cnt_d        = cnt_q;
    rd_valid_d   = rd_valid_q;
    row_d        = row_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_d        = out_q;

    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          unique case (opcode_e'(in_data_i.opcode))
            OpLoad: begin
              out_valid_d = 1'b1;
              out_d       = '{status: StatusOk, neighbor: '0, has_neighbor: 1'b0,
                              last: 1'b1};
              if ((LimW'(in_data_i.source_node) >= node_limit)
                  || (LimW'(in_data_i.target_node) >= node_limit)) begin
                out_d.status = StatusRange;
              end else if (total_q >= MaxEdgesT) begin
                out_d.status = StatusFull;
              end else begin
                total_d = total_q + TotW'(1);
              end
            end
            OpFetch: begin
              if (LimW'(in_data_i.query_row) >= node_limit) begin
                out_valid_d = 1'b1;
                out_d       = '{status: StatusRange, neighbor: '0, has_neighbor: 1'b0,
                                last: 1'b1};
              end else begin
                state_d      = StScan;
                row_d        = in_data_i.query_row;
                addr_d       = '0;
                cnt_d        = '0;
                rd_valid_d   = 1'b0;
                pend_valid_d = 1'b0;
              end
            end
            OpClear: begin
              total_d     = '0;
              out_valid_d = 1'b1;
              out_d       = '{status: StatusOk, neighbor: '0, has_neighbor: 1'b0,
                              last: 1'b1};
            end
            default: begin
              // The unused opcode is consumed without a result.
            end
          endcase
        end
      end

      StScan: begin
        if (cnt_q == CapC || (!rd_valid_q && addr_q == total_q)) begin
          state_d    = StFlush;
          rd_valid_d = 1'b0;
        end else if (!stall) begin
          if (hit) begin
            // Forward the held neighbor; it is not the last one.
            if (pend_valid_q) begin
              out_valid_d = 1'b1;
              out_d       = '{status: StatusOk, neighbor: pend_q, has_neighbor: 1'b1,
                              last: 1'b0};
            end
            pend_d       = mem_rdata.source;
            pend_valid_d = 1'b1;
            cnt_d        = cnt_q + ResultCntW'(1);
          end
          rd_valid_d = mem_re;
          if (mem_re) begin
            addr_d = addr_q + TotW'(1);
          end
        end
      end

      StFlush: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_d        = '{status: StatusOk, neighbor: pend_valid_q ? pend_q : '0,
                           has_neighbor: pend_valid_q, last: 1'b1};
          pend_valid_d = 1'b0;
          state_d      = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ sv/gat_checker.sv @@
module gat_checker
  import gat_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_data_o
);

  // A result that is not taken stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before its transfer");

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("result changed while stalled");

  // Every result without a neighbor closes its item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.has_neighbor |-> out_data_o.last)
    else $error("result without a neighbor lacks the last mark");

  // A neighbor is only ever reported with an ok status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.has_neighbor |-> out_data_o.status == StatusOk)
    else $error("neighbor reported with an error status");

  // The block does not take a new item while an unfinished neighbor run is offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last |-> !in_ready_o)
    else $error("input ready in the middle of a fetch");

endmodule

bind graph_adjacency_transpose gat_checker u_gat_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);

@@ sim/graph_adjacency_transpose_tb.sv @@
module graph_adjacency_transpose_tb
  import gat_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // The opcode that the block accepts but ignores. It has no member in the package enum.
  localparam logic [OpW-1:0] OpUnused = 2'd3;

  // Row that collects more edges than one fetch may return during the cap test.
  localparam logic [NodeW-1:0] HotRow = 6'd9;

  // Holds a mirror of the edge store and the node count. From these it works out the
  // results of every input transfer and keeps them in order until they come back.
  class transpose_scoreboard;
    logic [NodeW-1:0] src_mem [MaxEdgesDef];
    logic [NodeW-1:0] dst_mem [MaxEdgesDef];
    int unsigned      stored;
    logic [CfgW-1:0]  node_count;
    out_t             expected_q [$];
    int unsigned      errors;
    int unsigned      inputs_seen;
    int unsigned      results_seen;
    int unsigned      fetches;
    int unsigned      capped_rows;
    int unsigned      full_hits;
    int unsigned      range_hits;

    function new();
      stored     = 0;
      node_count = NodeCountRst;
      errors     = 0;
    endfunction

    // A node count above the store size saturates.
    function int unsigned node_limit();
      return (node_count > MaxNodesDef) ? MaxNodesDef : int'(node_count);
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void push(status_e st, logic [NodeW-1:0] nb, logic has, logic lst);
      out_t r;
      r.status       = st;
      r.neighbor     = nb;
      r.has_neighbor = has;
      r.last         = lst;
      expected_q.insert(expected_q.size(), r);
    endfunction

    function void note_input(in_t item);
      int unsigned      lim;
      logic [NodeW-1:0] hits [$];
      lim = node_limit();
      inputs_seen++;
      case (item.opcode)
        OpLoad: begin
          if (item.source_node >= lim || item.target_node >= lim) begin
            push(StatusRange, '0, 1'b0, 1'b1);
            range_hits++;
          end else if (stored >= MaxEdgesDef) begin
            push(StatusFull, '0, 1'b0, 1'b1);
            full_hits++;
          end else begin
            src_mem[stored] = item.source_node;
            dst_mem[stored] = item.target_node;
            stored++;
            push(StatusOk, '0, 1'b0, 1'b1);
          end
        end
        OpFetch: begin
          fetches++;
          if (item.query_row >= lim) begin
            push(StatusRange, '0, 1'b0, 1'b1);
            range_hits++;
          end else begin
            for (int unsigned i = 0; i < stored && hits.size() < ResultCap; i++) begin
              if (dst_mem[i] == item.query_row) hits.insert(hits.size(), src_mem[i]);
            end
            if (hits.size() == 0) begin
              push(StatusOk, '0, 1'b0, 1'b1);
            end else begin
              foreach (hits[i]) push(StatusOk, hits[i], 1'b1, i == hits.size() - 1);
              if (hits.size() == ResultCap) capped_rows++;
            end
          end
        end
        OpClear: begin
          stored = 0;
          push(StatusOk, '0, 1'b0, 1'b1);
        end
        default: begin
        end
      endcase
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("Field %s: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_t got);
      out_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        $error("Result transfer with nothing expected: status %0d neighbor %0d has %0b last %0b",
               got.status, got.neighbor, got.has_neighbor, got.last);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("neighbor", 32'(want.neighbor), 32'(got.neighbor));
      compare_field("has_neighbor", 32'(want.has_neighbor), 32'(got.has_neighbor));
      compare_field("last", 32'(want.last), 32'(got.last));
    endfunction
  endclass

  // Every input of the block starts at a known value.
  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            in_valid_i  = 1'b0;
  logic            in_ready_o;
  in_t             in_data_i   = '0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  out_t            out_data_o;
  logic            cfg_we_i    = 1'b0;
  logic [CfgW-1:0] cfg_wdata_i = '0;

  // Chance, in percent per cycle, that the sender or the receiver idles.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  transpose_scoreboard sb;

  graph_adjacency_transpose #(
    .MaxNodes(MaxNodesDef),
    .MaxEdges(MaxEdgesDef)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // The receiver decides afresh at every edge whether it can take a result. It
  // keeps doing so at every phase of the block's work, including long scans.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Both channels are sampled at the rising edge. The testbench drives with
  // nonblocking assignments, and the block's registers update the same way, so
  // the values seen here are the ones that were present before the edge.
  // An input transfer is noted before the result check. A result can never
  // belong to an input accepted at the same edge, so the order does not matter.
  always @(posedge clk_i) begin
    if (rst_ni && sb != null) begin
      if (in_valid_i && in_ready_o) sb.note_input(in_data_i);
      if (out_valid_o && out_ready_i) sb.check_result(out_data_o);
    end
  end

  function automatic in_t make_item(logic [OpW-1:0] op, logic [NodeW-1:0] src,
                                    logic [NodeW-1:0] dst, logic [NodeW-1:0] row);
    in_t item;
    item.opcode      = op;
    item.source_node = src;
    item.target_node = dst;
    item.query_row   = row;
    return item;
  endfunction

  // This task is called right after a rising edge. It may idle first, with valid
  // low. Then it raises valid with the payload and holds both until the transfer.
  // When it returns, valid is still high. The next call raises it again or idles,
  // so valid gets only one assignment in that time step.
  task automatic send_item(input in_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // This task stops sending and waits until every expected result has come back.
  // Then it waits a while longer, so the block is surely idle before the next
  // register write.
  task automatic drain_and_settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (MaxEdgesDef + 8) @(posedge clk_i);
  endtask

  // The register is only written while the block is idle. The mirror follows at
  // the edge that performs the write.
  task automatic set_node_count(input logic [CfgW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i      <= 1'b0;
    sb.node_count = value;
  endtask

  // Random traffic. Most items are well-formed loads and fetches whose targets
  // fall on a few hot rows, so fetches return runs of several neighbors. The rest
  // are clears, out-of-range nodes and fully random items, the ignored opcode
  // among them. Ignored items do not count toward the total.
  task automatic random_phase(input int unsigned items, input int unsigned send_pct,
                              input int unsigned recv_pct);
    in_t         item;
    int unsigned lim;
    int unsigned hot;
    int unsigned kind;
    int unsigned done;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    done = 0;
    while (done < items) begin
      item.opcode      = OpW'($urandom_range(3));
      item.source_node = NodeW'($urandom_range(63));
      item.target_node = NodeW'($urandom_range(63));
      item.query_row   = NodeW'($urandom_range(63));
      lim  = sb.node_limit();
      hot  = (lim < 6) ? lim : 6;
      kind = $urandom_range(99);
      if (kind < 55) begin
        item.opcode      = OpLoad;
        item.source_node = NodeW'($urandom_range(lim - 1));
        item.target_node = ($urandom_range(9) < 7) ? NodeW'($urandom_range(hot - 1))
                                                   : NodeW'($urandom_range(lim - 1));
      end else if (kind < 80) begin
        item.opcode    = OpFetch;
        item.query_row = ($urandom_range(9) < 7) ? NodeW'($urandom_range(hot - 1))
                                                 : NodeW'($urandom_range(lim - 1));
      end else if (kind < 88) begin
        // The nodes stay as drawn. Under a small node count they are mostly
        // out of range.
        item.opcode = $urandom_range(1) ? OpLoad : OpFetch;
      end else if (kind < 94) begin
        item.opcode = OpClear;
      end
      send_item(item);
      if (item.opcode != OpUnused) done++;
    end
  endtask

  // Loads one edge more into a single row than a fetch may return, so the fetch
  // stops at the cap. After a clear the row holds one edge again.
  task automatic overfill_row();
    for (int unsigned i = 0; i < ResultCap + 1; i++) begin
      send_item(make_item(OpLoad, NodeW'($urandom_range(63)), HotRow, '0));
    end
    send_item(make_item(OpFetch, '0, '0, HotRow));
    send_item(make_item(OpClear, '0, '0, '0));
    send_item(make_item(OpLoad, 6'd5, HotRow, '0));
    send_item(make_item(OpFetch, '0, '0, HotRow));
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the full node count. The nodes at the ends of the field are
    // loaded, including a duplicate edge. The rows come back in load order rather
    // than sorted. Then an empty row, the ignored opcode, and a fetch after a clear.
    send_idle_pct = 16;
    recv_idle_pct = 63;
    set_node_count(7'd64);
    send_item(make_item(OpLoad, 6'd0, 6'd0, '0));
    send_item(make_item(OpLoad, 6'd63, 6'd63, '0));
    send_item(make_item(OpLoad, 6'd0, 6'd63, '0));
    send_item(make_item(OpLoad, 6'd63, 6'd0, '0));
    send_item(make_item(OpLoad, 6'd63, 6'd63, '0));
    send_item(make_item(OpLoad, 6'd17, 6'd63, '0));
    send_item(make_item(OpFetch, '0, '0, 6'd63));
    send_item(make_item(OpFetch, '0, '0, 6'd0));
    send_item(make_item(OpFetch, '0, '0, 6'd30));
    send_item(make_item(OpUnused, 6'd63, 6'd63, 6'd63));
    send_item(make_item(OpClear, '0, '0, '0));
    send_item(make_item(OpFetch, '0, '0, 6'd63));
    drain_and_settle();

    // With a single node, only node zero is in range.
    set_node_count(7'd1);
    send_item(make_item(OpLoad, 6'd0, 6'd0, '0));
    send_item(make_item(OpLoad, 6'd1, 6'd0, '0));
    send_item(make_item(OpLoad, 6'd0, 6'd1, '0));
    send_item(make_item(OpFetch, '0, '0, 6'd0));
    send_item(make_item(OpFetch, '0, '0, 6'd1));
    drain_and_settle();

    // With a node count of zero, every load and fetch is out of range.
    set_node_count(7'd0);
    send_item(make_item(OpLoad, 6'd0, 6'd0, '0));
    send_item(make_item(OpFetch, '0, '0, 6'd0));
    send_item(make_item(OpClear, '0, '0, '0));
    drain_and_settle();

    // A node count above the store size saturates, so node 63 is still valid.
    set_node_count(7'd127);
    send_item(make_item(OpLoad, 6'd63, 6'd62, '0));
    send_item(make_item(OpFetch, '0, '0, 6'd62));
    send_item(make_item(OpFetch, '0, '0, 6'd63));
    drain_and_settle();

    // Random part in three idling phases. In the first, the sender idles rarely and
    // the receiver often. In the second, it is the other way round. In the third,
    // neither idles.
    set_node_count(7'd12);
    random_phase(10, 16, 63);
    drain_and_settle();
    set_node_count(7'd64);
    random_phase(10, 63, 16);
    drain_and_settle();
    set_node_count(7'd5);
    random_phase(10, 0, 0);
    drain_and_settle();

    // The loads of the cap test go without idling on the sender side, while the
    // receiver stalls often during the scans.
    set_node_count(7'd64);
    recv_idle_pct = 63;
    send_item(make_item(OpClear, '0, '0, '0));
    overfill_row();
    drain_and_settle();

    $display("Summary: %0d input transfers and %0d result transfers checked, %0d row fetches",
             sb.inputs_seen, sb.results_seen, sb.fetches);
    $display("Summary: %0d full-length rows, %0d store-full and %0d out-of-range statuses",
             sb.capped_rows, sb.full_hits, sb.range_hits);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // A hang anywhere, or a result that never arrives, ends the run here.
  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
